### rtl/tcfos_pkg.sv
// ----------------------------------------------------------------------------
// tcfos_pkg
// Shared types and constants for the two-class oldest-select FIFO.
// ----------------------------------------------------------------------------
package tcfos_pkg;

  localparam int DEPTH    = 16;
  localparam int TAG_BITS = 16;
  localparam int PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int STAMP_W  = 6;

  typedef enum logic [1:0] {
    REQ_ENQ     = 2'd0,
    REQ_DEQ_ANY = 2'd1,
    REQ_DEQ_C0  = 2'd2,
    REQ_DEQ_C1  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [STAMP_W-1:0]  stamp;
  } entry_t;

  // Advance a ring pointer, wrapping at DEPTH.
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

### rtl/two_class_fifo_oldest_select_core.sv
// ----------------------------------------------------------------------------
// two_class_fifo_oldest_select_core
// Two class FIFOs with a stamp compare that dequeues the oldest head.
// ----------------------------------------------------------------------------
// Each accepted item passes the input register, then the result register, and
// its result is shown with out_valid high for a single cycle.
// Throughput: one item per cycle; busy is always low, since each item is
// handled in a single pass by the logic between the two registers.
// The receiver cannot stall: each result is strobed for exactly one cycle.
// Reset (rst_n low, synchronous) empties both FIFOs, clears the arrival
// counter and drops any item in flight; storage contents are not cleared.
module two_class_fifo_oldest_select_core
  import tcfos_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_req_type,
  input  logic                in_item_class,
  input  logic [15:0]         in_item_tag,
  // result channel
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [15:0]         out_tag,
  output logic                out_class,
  output logic [4:0]          out_class0_count,
  output logic [4:0]          out_class1_count
);

  // --------------------------------------------------------------------------
  // Input register: capture every request; the item is never refused.
  // --------------------------------------------------------------------------
  logic                item_v_r;
  req_t                req_r;
  logic                cls_r;
  logic [TAG_BITS-1:0] tag_r;

  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // FIFO state: one ring per class, each entry holds tag and arrival stamp.
  // Entries are read only at the head, so a register file suffices.
  // --------------------------------------------------------------------------
  entry_t             mem_r  [2][DEPTH];
  logic [PTR_W-1:0]   head_r [2];
  logic [PTR_W-1:0]   tail_r [2];
  logic [CNT_W-1:0]   fill_r [2];
  logic [STAMP_W-1:0] arr_r;

  // --------------------------------------------------------------------------
  // Single-pass request logic
  // --------------------------------------------------------------------------
  entry_t             head0;
  entry_t             head1;
  logic               ne0;
  logic               ne1;
  logic [STAMP_W-1:0] stamp_diff;
  logic               full_sel;
  logic               do_enq;
  logic               do_deq;
  logic               pick_cls;
  status_t            status_nxt;
  logic [TAG_BITS-1:0] rtag_nxt;
  logic               rclass_nxt;
  logic [CNT_W-1:0]   fill0_nxt;
  logic [CNT_W-1:0]   fill1_nxt;

  assign head0      = mem_r[0][head_r[0]];
  assign head1      = mem_r[1][head_r[1]];
  assign ne0        = (fill_r[0] != '0);
  assign ne1        = (fill_r[1] != '0);
  // Modular stamp difference: MSB set means class 1 head is older.
  assign stamp_diff = head1.stamp - head0.stamp;
  assign full_sel   = (fill_r[cls_r] == CNT_W'(DEPTH));

  always_comb begin
    do_enq   = 1'b0;
    do_deq   = 1'b0;
    pick_cls = 1'b0;
    unique case (req_r)
      REQ_ENQ: begin
        do_enq = !full_sel;
      end
      REQ_DEQ_ANY: begin
        do_deq = ne0 || ne1;
        if (ne0 && ne1) begin
          pick_cls = stamp_diff[STAMP_W-1];
        end else begin
          pick_cls = !ne0;
        end
      end
      REQ_DEQ_C0: begin
        do_deq   = ne0;
        pick_cls = 1'b0;
      end
      REQ_DEQ_C1: begin
        do_deq   = ne1;
        pick_cls = 1'b1;
      end
      default: begin
        do_deq = 1'b0;
      end
    endcase
  end

  always_comb begin
    status_nxt = ST_OK;
    if (req_r == REQ_ENQ) begin
      if (full_sel) begin
        status_nxt = ST_FULL;
      end
    end else if (!do_deq) begin
      status_nxt = ST_EMPTY;
    end
  end

  // Zero the removed tag and class whenever nothing is removed.
  assign rtag_nxt   = !do_deq ? '0 : (pick_cls ? head1.tag : head0.tag);
  assign rclass_nxt = do_deq && pick_cls;

  always_comb begin
    fill0_nxt = fill_r[0];
    fill1_nxt = fill_r[1];
    if (item_v_r && do_enq) begin
      if (cls_r) begin
        fill1_nxt = fill_r[1] + CNT_W'(1);
      end else begin
        fill0_nxt = fill_r[0] + CNT_W'(1);
      end
    end else if (item_v_r && do_deq) begin
      if (pick_cls) begin
        fill1_nxt = fill_r[1] - CNT_W'(1);
      end else begin
        fill0_nxt = fill_r[0] - CNT_W'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r  <= 1'b0;
      out_valid <= 1'b0;
      head_r[0] <= '0;
      head_r[1] <= '0;
      tail_r[0] <= '0;
      tail_r[1] <= '0;
      fill_r[0] <= '0;
      fill_r[1] <= '0;
      arr_r     <= '0;
    end else begin
      item_v_r  <= start && !busy;
      out_valid <= item_v_r;
      fill_r[0] <= fill0_nxt;
      fill_r[1] <= fill1_nxt;
      if (item_v_r && do_enq) begin
        // advance the tail of the class written and stamp the next arrival
        tail_r[cls_r] <= ptr_inc(tail_r[cls_r]);
        arr_r         <= arr_r + STAMP_W'(1);
      end
      if (item_v_r && do_deq) begin
        head_r[pick_cls] <= ptr_inc(head_r[pick_cls]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers: input capture, storage write, result hold
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r <= req_t'(in_req_type);
      cls_r <= in_item_class;
      tag_r <= TAG_BITS'(in_item_tag);
    end
    if (item_v_r && do_enq) begin
      mem_r[cls_r][tail_r[cls_r]] <= '{tag: tag_r, stamp: arr_r};
    end
    if (item_v_r) begin
      out_status       <= status_nxt;
      out_tag          <= 16'(rtag_nxt);
      out_class        <= rclass_nxt;
      out_class0_count <= 5'(fill0_nxt);
      out_class1_count <= 5'(fill1_nxt);
    end
  end

`ifndef SYNTH
  // Neither FIFO ever holds more than DEPTH entries.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r[0] <= CNT_W'(DEPTH)) && (fill_r[1] <= CNT_W'(DEPTH)))
    else $error("class fill count above depth");

  // An empty or full class 0 ring has its head and tail pointers together.
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    ((fill_r[0] == '0) || (fill_r[0] == CNT_W'(DEPTH))) |-> (head_r[0] == tail_r[0]))
    else $error("class 0 pointers disagree with fill count");

  // Every captured item gives exactly one result strobe, in the following cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    item_v_r |=> out_valid)
    else $error("captured item produced no result");

  // A successful enqueue advances the arrival stamp by one.
  a_stamp_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (item_v_r && do_enq) |=> (arr_r == $past(arr_r) + STAMP_W'(1)))
    else $error("arrival stamp did not advance on enqueue");

  // A dequeue never selects an empty class.
  a_pick_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (item_v_r && do_deq) |-> (pick_cls ? ne1 : ne0))
    else $error("dequeue selected an empty class");
`endif

endmodule
